### src/assert_macros.svh
// shared assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define SCPD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// consequence holds in the same cycle as the trigger
`define SCPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// consequence holds in the cycle after the trigger
`define SCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### src/scpd_pkg.sv
`default_nettype none

package scpd_pkg;

    // default geometry
    localparam int PACKET_BYTES_DEF   = 18;
    localparam int CRC_SPAN_BYTES_DEF = 16;

    // register reset values
    localparam logic [7:0] SYNC_RESET = 8'hAA;
    localparam logic [7:0] TYPE_RESET = 8'h02;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SYNC = 1'b0,
        CFG_TYPE = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

### src/scpd_crc.sv
`default_nettype none

module scpd_crc #(
    parameter int SPAN_BYTES = scpd_pkg::CRC_SPAN_BYTES_DEF
) (
    input  wire logic [SPAN_BYTES*8-1:0] i_data,
    output logic      [15:0]             o_crc
);

    localparam int NBITS = SPAN_BYTES * 8;

    // serial crc of a span that is all zero except one bit (none when bit_idx < 0)
    function automatic logic [15:0] crc_run(input logic [15:0] init, input int bit_idx);
        logic [15:0] crc;
        logic [7:0]  bt;
        int          i;
        int          b;
        crc = init;
        for (i = 0; i < SPAN_BYTES; i++) begin
            bt = 8'h00;
            if (bit_idx >= 0 && (bit_idx >> 3) == i) begin
                bt = 8'h01 << (bit_idx & 7);
            end
            crc = crc ^ {bt, 8'h00};
            for (b = 0; b < 8; b++) begin
                if ((crc & scpd_pkg::CRC_TOP) != 16'h0000) begin
                    crc = (crc << 1) ^ scpd_pkg::CRC_POLY;
                end else begin
                    crc = crc << 1;
                end
            end
        end
        return crc;
    endfunction

    // column of the crc matrix for every data bit
    function automatic logic [16*NBITS-1:0] crc_columns();
        logic [16*NBITS-1:0] cols;
        int                  j;
        cols = '0;
        for (j = 0; j < NBITS; j++) begin
            cols[j*16 +: 16] = crc_run(16'h0000, j);
        end
        return cols;
    endfunction

    localparam logic [16*NBITS-1:0] CRC_COLS  = crc_columns();
    localparam logic [15:0]         CRC_CONST = crc_run(scpd_pkg::CRC_INIT, -1);

    // parallel xor tree: initial-value term plus one column per set data bit
    always_comb begin
        o_crc = CRC_CONST;
        for (int j = 0; j < NBITS; j++) begin
            if (i_data[j]) begin
                o_crc = o_crc ^ CRC_COLS[j*16 +: 16];
            end
        end
    end

endmodule

`default_nettype wire

### src/sync_crc_packet_detector.sv
// the window register loads on an accepted request and the result register loads from it
//   when the window stage advances, which a stall on the result channel can hold off
// throughput: one byte per cycle when the output is not stalled; the window register and
//   result register form a two-entry pipeline, so a new byte is taken while a result waits
// the crc over the window's leading span is one parallel xor tree between the two registers
// reset (synchronous, active low): window zeroed, fill count zero, configuration registers to defaults
`default_nettype none
`include "assert_macros.svh"

module sync_crc_packet_detector #(
    parameter int PACKET_BYTES   = scpd_pkg::PACKET_BYTES_DEF,
    parameter int CRC_SPAN_BYTES = scpd_pkg::CRC_SPAN_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_clear_history,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_packet_found,
    output logic [15:0]      o_packet_crc,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int WIN_BITS  = PACKET_BYTES * 8;
    localparam int FILL_W    = $clog2(PACKET_BYTES + 1);
    localparam int CRC_BYTES = (CRC_SPAN_BYTES < PACKET_BYTES) ? CRC_SPAN_BYTES
                                                              : PACKET_BYTES;
    localparam bit FIELD_FITS = (CRC_SPAN_BYTES + 2) <= PACKET_BYTES;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PACKET_BYTES);

    logic [7:0]          r_sync;
    logic [7:0]          r_type;
    logic [WIN_BITS-1:0] r_window;
    logic [WIN_BITS-1:0] n_window;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic                r_s1_valid;
    logic                r_out_valid;
    logic                r_found;
    logic [15:0]         r_crc;

    logic                in_accept;
    logic                s1_advance;
    logic [15:0]         crc_calc;
    logic [15:0]         crc_field;
    logic                found_calc;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= scpd_pkg::SYNC_RESET;
            r_type <= scpd_pkg::TYPE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                scpd_pkg::CFG_SYNC: r_sync <= i_cfg_data;
                scpd_pkg::CFG_TYPE: r_type <= i_cfg_data;
            endcase
        end
    end

    // handshake: window stage frees up when its result moves on
    assign s1_advance = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // window shift, newest byte at the top, optional clear first
    always_comb begin
        if (i_clear_history) begin
            n_window = {i_data_byte, {(WIN_BITS-8){1'b0}}};
            n_fill   = FILL_W'(1);
        end else begin
            n_window = {i_data_byte, r_window[WIN_BITS-1:8]};
            n_fill   = (r_fill < FILL_FULL) ? r_fill + FILL_W'(1) : r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_window   <= n_window;
                r_fill     <= n_fill;
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // crc over the leading span of the window
    scpd_crc #(
        .SPAN_BYTES(CRC_BYTES)
    ) u_crc (
        .i_data(r_window[CRC_BYTES*8-1:0]),
        .o_crc (crc_calc)
    );

    // little-endian crc field, missing bytes read as zero
    generate
        if (FIELD_FITS) begin : g_field_full
            assign crc_field = r_window[CRC_SPAN_BYTES*8 +: 16];
        end else if (CRC_SPAN_BYTES + 1 == PACKET_BYTES) begin : g_field_half
            assign crc_field = {8'h00, r_window[CRC_SPAN_BYTES*8 +: 8]};
        end else begin : g_field_none
            assign crc_field = 16'h0000;
        end
    endgenerate

    // packet match
    assign found_calc = FIELD_FITS
                     && (r_fill == FILL_FULL)
                     && (r_window[7:0] == r_sync)
                     && (r_window[15:8] == r_type)
                     && (crc_calc == crc_field);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_found <= found_calc;
            r_crc   <= crc_field;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packet_found = r_found;
    assign o_packet_crc   = r_crc;

    // checks
    `SCPD_ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill <= FILL_FULL)
    `SCPD_ASSERT_NEXT(a_clear_fill, i_clk, i_rst_n, in_accept && i_clear_history,
        r_fill == FILL_W'(1))
    `SCPD_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n,
        in_accept && !i_clear_history && (r_fill < FILL_FULL),
        r_fill == $past(r_fill) + FILL_W'(1))
    `SCPD_ASSERT_SAME(a_full_stalls, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && i_out_stall, o_in_stall)

endmodule

`default_nettype wire
